// ===== sv/lmfs_pkg.sv =====
// Package for the two-wire LED matrix frame sender.
// Holds request codes, sequencer phase type, register indexes and reset values.
// No dependencies.
package lmfs_pkg;

  localparam int unsigned FrameBytesDef = 16;
  localparam int unsigned StoreDepth    = 16;
  localparam int unsigned IdxW          = 4;
  localparam int unsigned CntW          = 5;

  localparam logic [7:0] AddrCmdRst = 8'hC0;
  localparam logic [7:0] CtrlCmdRst = 8'h8A;
  localparam logic [7:0] HalfRst    = 8'd3;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_SEND  = 2'd2,
    REQ_BLANK = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_ADDR_CMD = 2'd0,
    CFG_CTRL_CMD = 2'd1,
    CFG_HALF     = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_S1   = 3'd1,
    PH_S2   = 3'd2,
    PH_LO   = 3'd3,
    PH_HI   = 3'd4,
    PH_E1   = 3'd5,
    PH_E2   = 3'd6,
    PH_E3   = 3'd7
  } phase_e;

  typedef struct packed {
    logic clock_pin;
    logic data_pin;
    logic busy;
    logic rejected;
  } res_t;

endpackage

// ===== sv/lmfs_store.sv =====
// Pattern store: 16 column bytes, cleared at reset.
// One write port, one registered read port. Depends on lmfs_pkg.
module lmfs_store
  import lmfs_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [IdxW-1:0] widx_i,
  input  logic [7:0]      wdata_i,
  input  logic [IdxW-1:0] ridx_i,
  output logic [7:0]      rdata_o
);

  logic [7:0] mem_q [StoreDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) begin
        mem_q[i] <= '0;
      end
    end else if (we_i) begin
      mem_q[widx_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdata_q <= '0;
    end else begin
      rdata_q <= mem_q[ridx_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/lmfs_seq.sv =====
// Frame sequencer: phase, byte/bit/tick counters and shift byte.
// Produces next pin levels and status per item. Depends on lmfs_pkg.
module lmfs_seq
  import lmfs_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [1:0]      req_i,
  input  logic [7:0]      addr_cmd_i,
  input  logic [7:0]      ctrl_cmd_i,
  input  logic [7:0]      half_i,
  input  logic [7:0]      store_data_i,
  output logic [IdxW-1:0] store_ridx_o,
  output logic            busy_o,
  output res_t            res_o
);

  localparam logic [CntW-1:0] LastPat = CntW'(FRAME_BYTES);
  localparam logic [CntW-1:0] EndCnt  = CntW'(FRAME_BYTES + 1);

  phase_e          phase_q, phase_d;
  logic [CntW-1:0] byte_q, byte_d;
  logic [2:0]      bit_q, bit_d;
  logic [7:0]      tick_q, tick_d;
  logic [7:0]      shift_q, shift_d;
  logic            blank_q, blank_d;

  logic [CntW-1:0] byte_inc;
  logic [CntW-1:0] load_cnt;
  logic [7:0]      load_byte;
  logic [8:0]      tick_inc;
  logic [7:0]      hp;
  logic            rej;

  assign busy_o   = (phase_q != PH_IDLE);
  assign byte_inc = byte_q + CntW'(1);
  assign load_cnt = (phase_q == PH_S2) ? byte_q : byte_inc;
  // store read is registered; pattern loads use the entry at the byte count, or zero when blanking
  assign store_ridx_o = byte_d[IdxW-1:0];

  always_comb begin
    if (load_cnt == '0) begin
      load_byte = addr_cmd_i;
    end else if (load_cnt <= LastPat) begin
      load_byte = blank_q ? 8'h00 : store_data_i;
    end else begin
      load_byte = ctrl_cmd_i;
    end
  end

  assign hp       = (half_i == 8'd0) ? 8'd1 : half_i;
  assign tick_inc = {1'b0, tick_q} + 9'd1;

  // next state
  always_comb begin
    phase_d = phase_q;
    byte_d  = byte_q;
    bit_d   = bit_q;
    tick_d  = tick_q;
    shift_d = shift_q;
    blank_d = blank_q;
    rej     = 1'b0;
    if (step_i) begin
      if (phase_q != PH_IDLE) begin
        rej = (req_i != REQ_TICK);
        if (tick_inc >= {1'b0, hp}) begin
          tick_d = '0;
          unique case (phase_q)
            PH_S1: phase_d = PH_S2;
            PH_S2: begin
              bit_d   = '0;
              shift_d = load_byte;
              phase_d = PH_LO;
            end
            PH_LO: phase_d = PH_HI;
            PH_HI: begin
              if (bit_q != 3'd7) begin
                bit_d   = bit_q + 3'd1;
                shift_d = {1'b0, shift_q[7:1]};
                phase_d = PH_LO;
              end else begin
                bit_d  = '0;
                byte_d = byte_inc;
                if (byte_inc >= EndCnt) begin
                  phase_d = PH_E1;
                end else begin
                  shift_d = load_byte;
                  phase_d = PH_LO;
                end
              end
            end
            PH_E1: phase_d = PH_E2;
            PH_E2: phase_d = PH_E3;
            PH_E3: begin
              if (byte_q == EndCnt) begin
                phase_d = PH_S1;
              end else begin
                byte_d  = '0;
                shift_d = '0;
                blank_d = 1'b0;
                phase_d = PH_IDLE;
              end
            end
            default: phase_d = PH_IDLE;
          endcase
        end else begin
          tick_d = tick_inc[7:0];
        end
      end else if (req_i == REQ_SEND || req_i == REQ_BLANK) begin
        blank_d = (req_i == REQ_BLANK);
        byte_d  = '0;
        bit_d   = '0;
        shift_d = '0;
        tick_d  = '0;
        phase_d = PH_S1;
      end
    end
  end

  // outputs: pin levels after this item
  always_comb begin
    res_o.busy     = (phase_d != PH_IDLE);
    res_o.rejected = rej;
    unique case (phase_d)
      PH_S2: begin
        res_o.clock_pin = 1'b1;
        res_o.data_pin  = 1'b0;
      end
      PH_LO: begin
        res_o.clock_pin = 1'b0;
        res_o.data_pin  = shift_d[0];
      end
      PH_HI: begin
        res_o.clock_pin = 1'b1;
        res_o.data_pin  = shift_d[0];
      end
      PH_E1: begin
        res_o.clock_pin = 1'b0;
        res_o.data_pin  = 1'b0;
      end
      PH_E2: begin
        res_o.clock_pin = 1'b1;
        res_o.data_pin  = 1'b0;
      end
      default: begin
        res_o.clock_pin = 1'b1;
        res_o.data_pin  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      byte_q  <= '0;
      bit_q   <= '0;
      tick_q  <= '0;
      shift_q <= '0;
      blank_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      byte_q  <= byte_d;
      bit_q   <= bit_d;
      tick_q  <= tick_d;
      shift_q <= shift_d;
      blank_q <= blank_d;
    end
  end

endmodule

// ===== sv/led_matrix_frame_serializer.sv =====
// Two-wire LED matrix frame sender, top level.
// Config registers, input handshake, output register. Uses lmfs_pkg,
// lmfs_store and lmfs_seq.
//
// Usage: every input item (tick, write, send, blank send) yields exactly one
// result item carrying the clock and data pin levels after that item, a busy
// flag and a rejected flag. Ticks pace the frame: each pin phase holds for
// half_period_ticks items. Write and send are honored only while idle;
// while a frame is out they are flagged rejected and count as ticks.
// The result is in the output register the cycle after the item is
// accepted. Throughput: one item per cycle while results are taken, set
// by the single output register; in_ready_o stays high while the output is
// empty or being taken in the same cycle.
// Receiver stall: the result holds in the output register and in_ready_o
// drops until it is taken; no state advances meanwhile.
// Reset: pattern store cleared, sequencer idle, result register not reset,
// registers at 0xC0 / 0x8A / 3, no result pending.
// Config writes take effect on the edge where cfg_we_i is high.
module led_matrix_frame_serializer
  import lmfs_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = FrameBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [7:0]      cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      req_type_i,
  input  logic [IdxW-1:0] byte_index_i,
  input  logic [7:0]      byte_value_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            clock_pin_o,
  output logic            data_pin_o,
  output logic            busy_res_o,
  output logic            rejected_o
);

  logic [7:0]      addr_cmd_q, ctrl_cmd_q, half_q;
  logic            out_valid_q, out_valid_d;
  res_t            res_q, res_d;
  logic            in_acc;
  logic            busy;
  logic            store_we;
  logic [IdxW-1:0] store_ridx;
  logic [7:0]      store_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_cmd_q <= AddrCmdRst;
      ctrl_cmd_q <= CtrlCmdRst;
      half_q     <= HalfRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ADDR_CMD: addr_cmd_q <= cfg_wdata_i;
        CFG_CTRL_CMD: ctrl_cmd_q <= cfg_wdata_i;
        CFG_HALF:     half_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign store_we   = in_acc && !busy && (req_type_i == REQ_WRITE);

  lmfs_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (store_we),
    .widx_i  (byte_index_i),
    .wdata_i (byte_value_i),
    .ridx_i  (store_ridx),
    .rdata_o (store_rdata)
  );

  lmfs_seq #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_acc),
    .req_i        (req_type_i),
    .addr_cmd_i   (addr_cmd_q),
    .ctrl_cmd_i   (ctrl_cmd_q),
    .half_i       (half_q),
    .store_data_i (store_rdata),
    .store_ridx_o (store_ridx),
    .busy_o       (busy),
    .res_o        (res_d)
  );

  always_comb begin
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign clock_pin_o = res_q.clock_pin;
  assign data_pin_o  = res_q.data_pin;
  assign busy_res_o  = res_q.busy;
  assign rejected_o  = res_q.rejected;

endmodule

// ===== sv/lmfs_checker.sv =====
// Port-level checker for the frame sender, bound to the top level.
// Depends only on the top-level ports.
module lmfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       clock_pin_o,
  input logic       data_pin_o,
  input logic       busy_res_o,
  input logic       rejected_o
);

  // idle result always shows idle line levels
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !busy_res_o |-> clock_pin_o && data_pin_o)
    else $error("idle result with non-idle pins");

  // input only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled with output free");

  // an accepted item always yields a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item produced no result");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({clock_pin_o, data_pin_o, busy_res_o, rejected_o}))
    else $error("stalled result changed");

endmodule

bind led_matrix_frame_serializer lmfs_checker u_lmfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .clock_pin_o (clock_pin_o),
  .data_pin_o  (data_pin_o),
  .busy_res_o  (busy_res_o),
  .rejected_o  (rejected_o)
);
